// ===== design/glr_pkg.sv =====
// ----------------------------------------------------------------------------
// glr_pkg
// shared types, constants and codes of the gradient line rasterizer
// ----------------------------------------------------------------------------
package glr_pkg;

  localparam int CoordW = 13;
  localparam int SpanW  = 14;
  localparam int ErrW   = 16;
  localparam int ColorW = 24;
  localparam int SqW    = 2 * SpanW;
  localparam int DistW  = SqW + 1;
  localparam int QuotW  = 33;
  localparam int RootW  = 34;
  localparam int FracW  = 17;
  localparam int DivCntW  = 6;
  localparam int RootCntW = 5;

  localparam logic signed [CoordW-1:0] ImageWidth  = 13'sd1024;
  localparam logic signed [CoordW-1:0] ImageHeight = 13'sd768;

  localparam logic [FracW-1:0]    PosOne     = 17'h10000;
  localparam logic [DivCntW-1:0]  DivSteps   = 6'd33;
  localparam logic [RootCntW-1:0] RootSteps  = 5'd17;
  localparam logic [RootW-1:0]    RootBit0   = 34'h1_0000_0000;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } opcode_t;

  typedef enum logic {
    REG_FIRST_COLOR  = 1'b0,
    REG_SECOND_COLOR = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    MODE_SECOND = 2'd0,
    MODE_FIRST  = 2'd1,
    MODE_BLEND  = 2'd2,
    MODE_SPARE  = 2'd3
  } color_mode_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SQUARE,
    B_SUM,
    B_DIV,
    B_ROOT,
    B_MIX,
    B_OUT
  } back_state_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic                     in_image;
    logic                     last;
    color_mode_t              mode;
    logic [SpanW-1:0]         cx;
    logic [SpanW-1:0]         cy;
    logic [SpanW-1:0]         fx;
    logic [SpanW-1:0]         fy;
  } pixel_task_t;

endpackage

// ===== design/glr_front.sv =====
// ----------------------------------------------------------------------------
// glr_front
// load and step decoding, bresenham walk, pixel task generation
// ----------------------------------------------------------------------------
module glr_front
  import glr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  opcode_t                  opcode,
  input  logic signed [CoordW-1:0] x_start,
  input  logic signed [CoordW-1:0] y_start,
  input  logic signed [CoordW-1:0] x_end,
  input  logic signed [CoordW-1:0] y_end,
  input  logic signed [15:0]       z_start,
  input  logic signed [15:0]       z_end,
  output logic                     task_push,
  output pixel_task_t              task_data
);

  logic signed [CoordW-1:0] cur_x, cur_y, origin_x, origin_y, target_x, target_y;
  logic [SpanW-1:0]         span_x, span_y;
  logic                     step_x_neg, step_y_neg, active;
  logic signed [ErrW-1:0]   error_term;
  color_mode_t              color_mode;

  logic signed [SpanW-1:0]  ld_dx, ld_dy, cx_s, cy_s;
  logic [SpanW-1:0]         ld_sx, ld_sy;
  logic signed [ErrW:0]     e2;
  logic                     mv_x, mv_y;
  logic signed [CoordW-1:0] nx, ny;
  logic signed [ErrW-1:0]   err_next;
  color_mode_t              ld_mode;

  always_comb begin
    ld_dx = {x_end[CoordW-1], x_end} - {x_start[CoordW-1], x_start};
    ld_dy = {y_end[CoordW-1], y_end} - {y_start[CoordW-1], y_start};
    ld_sx = ld_dx[SpanW-1] ? -ld_dx : ld_dx;
    ld_sy = ld_dy[SpanW-1] ? -ld_dy : ld_dy;
    if (z_start == z_end) begin
      ld_mode = (z_start == 16'sd0) ? MODE_SECOND : MODE_FIRST;
    end else begin
      ld_mode = MODE_BLEND;
    end

    e2   = {error_term, 1'b0};
    mv_x = e2 > -$signed({{(ErrW-SpanW+1){1'b0}}, span_y});
    mv_y = e2 < $signed({{(ErrW-SpanW+1){1'b0}}, span_x});
    err_next = error_term;
    nx = cur_x;
    ny = cur_y;
    if (mv_x) begin
      err_next = err_next - $signed({{(ErrW-SpanW){1'b0}}, span_y});
      nx = step_x_neg ? cur_x - 13'sd1 : cur_x + 13'sd1;
    end
    if (mv_y) begin
      err_next = err_next + $signed({{(ErrW-SpanW){1'b0}}, span_x});
      ny = step_y_neg ? cur_y - 13'sd1 : cur_y + 13'sd1;
    end

    cx_s = {cur_x[CoordW-1], cur_x} - {origin_x[CoordW-1], origin_x};
    cy_s = {cur_y[CoordW-1], cur_y} - {origin_y[CoordW-1], origin_y};

    task_push          = accept && (opcode == OP_STEP) && active;
    task_data.x        = cur_x;
    task_data.y        = cur_y;
    task_data.in_image = !cur_x[CoordW-1] && (cur_x <= ImageWidth) &&
                         !cur_y[CoordW-1] && (cur_y <= ImageHeight);
    task_data.last     = (nx == target_x) && (ny == target_y);
    task_data.mode     = color_mode;
    task_data.cx       = cx_s[SpanW-1] ? -cx_s : cx_s;
    task_data.cy       = cy_s[SpanW-1] ? -cy_s : cy_s;
    task_data.fx       = span_x;
    task_data.fy       = span_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x <= '0; cur_y <= '0; origin_x <= '0; origin_y <= '0;
      target_x <= '0; target_y <= '0; span_x <= '0; span_y <= '0;
      step_x_neg <= 1'b0; step_y_neg <= 1'b0; error_term <= '0;
      color_mode <= MODE_SECOND; active <= 1'b0;
    end else if (accept && opcode == OP_LOAD) begin
      origin_x   <= x_start;
      origin_y   <= y_start;
      target_x   <= x_end;
      target_y   <= y_end;
      cur_x      <= x_start;
      cur_y      <= y_start;
      span_x     <= ld_sx;
      span_y     <= ld_sy;
      step_x_neg <= !(x_start < x_end);
      step_y_neg <= !(y_start < y_end);
      error_term <= $signed({2'b00, ld_sx}) - $signed({2'b00, ld_sy});
      color_mode <= ld_mode;
      active     <= !((x_start == x_end) && (y_start == y_end));
    end else if (task_push) begin
      cur_x      <= nx;
      cur_y      <= ny;
      error_term <= err_next;
      if (task_data.last) begin
        active <= 1'b0;
      end
    end
  end

endmodule

// ===== design/glr_queue.sv =====
// ----------------------------------------------------------------------------
// glr_queue
// two-entry task queue between the stepper and the color unit
// ----------------------------------------------------------------------------
module glr_queue
  import glr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  pixel_task_t push_data,
  input  logic        pop,
  output logic        full,
  output logic        empty,
  output pixel_task_t head
);

  pixel_task_t slots [2];
  logic        wr_ptr, rd_ptr;
  logic [1:0]  count;

  assign full  = count == 2'd2;
  assign empty = count == 2'd0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/glr_back.sv =====
// ----------------------------------------------------------------------------
// glr_back
// color unit: distance ratio by long division and square root, channel blend
// ----------------------------------------------------------------------------
module glr_back
  import glr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              task_valid,
  input  pixel_task_t       task_data,
  output logic              task_pop,
  input  logic [ColorW-1:0] first_color,
  input  logic [ColorW-1:0] second_color,
  input  logic              out_free,
  output logic              res_valid,
  output pixel_task_t       res_task,
  output logic [ColorW-1:0] res_color
);

  back_state_t state, state_next;

  pixel_task_t          cur;
  logic [SqW-1:0]       sq_cx, sq_cy, sq_fx, sq_fy;
  logic [DistW-1:0]     c2, f2;
  logic [DistW-1:0]     rem;
  logic                 low_bit;
  logic [QuotW-1:0]     quot;
  logic [DivCntW-1:0]   div_cnt;
  logic [RootW-1:0]     rn, rr, rbit;
  logic [RootCntW-1:0]  root_cnt;
  logic [ColorW-1:0]    color;

  logic [DistW:0]       trial;
  logic [RootW-1:0]     rsum;
  logic [FracW-1:0]     pos, pos_inv;
  logic [ColorW-1:0]    mixed;
  logic [FracW+8:0]     ch_sum [3];

  always_comb begin
    trial = {rem, low_bit};
    rsum  = rr + rbit;
    pos   = (rr > {{(RootW-FracW){1'b0}}, PosOne}) ? PosOne : rr[FracW-1:0];
    pos_inv = PosOne - pos;
    for (int i = 0; i < 3; i++) begin
      ch_sum[i] = {9'd0, pos_inv} * {18'd0, first_color[8*i +: 8]} +
                  {9'd0, pos} * {18'd0, second_color[8*i +: 8]} + 26'h8000;
      mixed[8*i +: 8] = (ch_sum[i][FracW+8:16] > 10'd255) ? 8'hff : ch_sum[i][23:16];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:   if (task_valid) state_next = B_SQUARE;
      B_SQUARE: state_next = (cur.mode == MODE_SECOND || cur.mode == MODE_FIRST) ?
                             B_OUT : B_SUM;
      B_SUM:    state_next = B_DIV;
      B_DIV:    if (div_cnt == DivSteps - 6'd1) state_next = B_ROOT;
      B_ROOT:   if (root_cnt == RootSteps - 5'd1) state_next = B_MIX;
      B_MIX:    state_next = B_OUT;
      B_OUT:    if (out_free) state_next = B_IDLE;
      default:  state_next = B_IDLE;
    endcase
  end

  always_comb begin
    task_pop  = (state == B_IDLE) && task_valid;
    res_valid = (state == B_OUT) && out_free;
    res_task  = cur;
    res_color = color;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        cur <= task_data;
      end
      B_SQUARE: begin
        sq_cx <= cur.cx * cur.cx;
        sq_cy <= cur.cy * cur.cy;
        sq_fx <= cur.fx * cur.fx;
        sq_fy <= cur.fy * cur.fy;
        color <= (cur.mode == MODE_SECOND) ? second_color : first_color;
      end
      B_SUM: begin
        c2       <= {1'b0, sq_cx} + {1'b0, sq_cy};
        f2       <= {1'b0, sq_fx} + {1'b0, sq_fy};
        rem      <= {2'b00, sq_cx[SqW-1:1]} + {2'b00, sq_cy[SqW-1:1]} +
                    {{DistW-1{1'b0}}, sq_cx[0] & sq_cy[0]};
        low_bit  <= sq_cx[0] ^ sq_cy[0];
        quot     <= '0;
        div_cnt  <= '0;
      end
      B_DIV: begin
        if (f2 != '0 && trial >= {1'b0, f2}) begin
          rem  <= DistW'(trial - {1'b0, f2});
          quot <= {quot[QuotW-2:0], 1'b1};
        end else begin
          rem  <= trial[DistW-1:0];
          quot <= {quot[QuotW-2:0], 1'b0};
        end
        low_bit  <= 1'b0;
        div_cnt  <= div_cnt + 6'd1;
        rr       <= '0;
        rbit     <= RootBit0;
        root_cnt <= '0;
        if (div_cnt == DivSteps - 6'd1) begin
          rn <= (f2 == '0) ? {RootW{1'b0}} : {1'b0, quot[QuotW-2:0], (trial >= {1'b0, f2})};
        end else begin
          rn <= '0;
        end
      end
      B_ROOT: begin
        if (f2 == '0) begin
          rr <= {{(RootW-FracW){1'b0}}, PosOne};
        end else if (rn >= rsum) begin
          rn <= rn - rsum;
          rr <= (rr >> 1) + rbit;
        end else begin
          rr <= rr >> 1;
        end
        rbit     <= rbit >> 2;
        root_cnt <= root_cnt + 5'd1;
      end
      B_MIX: begin
        color <= mixed;
      end
      default: begin
        color <= color;
      end
    endcase
  end

endmodule

// ===== design/gradient_line_rasterizer_top.sv =====
// ----------------------------------------------------------------------------
// gradient_line_rasterizer_top
// bresenham line stepper with flat or distance-blended pixel color
// ----------------------------------------------------------------------------
// input queue side: push with opcode and line fields while full is low.
// a load request stores a line and gives no pixel; a step request on an
// active line gives one pixel, a step with no line gives nothing.
// result queue side: a pixel waits on the ports while empty is low and
// leaves on pop. cfg_valid/cfg_ready writes first_color or second_color;
// cfg_ready is always high, writes belong in idle periods.
// the stepper takes one request per cycle while full is low, into a
// two-entry task queue. the color unit handles one pixel at a time: a
// flat color pixel passes the square state, which picks its color, and
// the out state; a blended pixel passes the square, sum, 33-step divider,
// 17-step square root and mix states before the out state. a pixel in
// the out state loads into the output registers once a pop has cleared
// out_valid. when the result is not popped the color unit holds, the task
// queue fills, full rises. reset empties both queues and drops the line.
// ----------------------------------------------------------------------------
module gradient_line_rasterizer_top
  import glr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  logic                     opcode,
  input  logic signed [CoordW-1:0] x_start,
  input  logic signed [CoordW-1:0] y_start,
  input  logic signed [CoordW-1:0] x_end,
  input  logic signed [CoordW-1:0] y_end,
  input  logic signed [15:0]       z_start,
  input  logic signed [15:0]       z_end,
  output logic                     empty,
  input  logic                     pop,
  output logic signed [CoordW-1:0] pixel_x,
  output logic signed [CoordW-1:0] pixel_y,
  output logic [ColorW-1:0]        pixel_color,
  output logic                     inside_res,
  output logic                     last,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic                     cfg_index,
  input  logic [ColorW-1:0]        cfg_data
);

  logic [ColorW-1:0] first_color, second_color;
  logic              accept, task_push, task_pop, q_empty, out_valid, res_valid;
  pixel_task_t       task_in, task_head, res_task;
  logic [ColorW-1:0] res_color;

  assign accept    = push && !full;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_color  <= '0;
      second_color <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_index_t'(cfg_index))
        REG_FIRST_COLOR:  first_color  <= cfg_data;
        REG_SECOND_COLOR: second_color <= cfg_data;
        default:          first_color  <= first_color;
      endcase
    end
  end

  glr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .opcode    (opcode_t'(opcode)),
    .x_start   (x_start),
    .y_start   (y_start),
    .x_end     (x_end),
    .y_end     (y_end),
    .z_start   (z_start),
    .z_end     (z_end),
    .task_push (task_push),
    .task_data (task_in)
  );

  glr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (task_push),
    .push_data (task_in),
    .pop       (task_pop),
    .full      (full),
    .empty     (q_empty),
    .head      (task_head)
  );

  glr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .task_valid   (!q_empty),
    .task_data    (task_head),
    .task_pop     (task_pop),
    .first_color  (first_color),
    .second_color (second_color),
    .out_free     (!out_valid),
    .res_valid    (res_valid),
    .res_task     (res_task),
    .res_color    (res_color)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (pop && out_valid) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      pixel_x     <= res_task.x;
      pixel_y     <= res_task.y;
      inside_res  <= res_task.in_image;
      last        <= res_task.last;
      pixel_color <= res_color;
    end
  end

  assign empty = !out_valid;

endmodule

// ===== design/glr_checker.sv =====
// ----------------------------------------------------------------------------
// glr_checker
// port-level checks of the gradient line rasterizer
// ----------------------------------------------------------------------------
module glr_checker
  import glr_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     empty,
  input logic                     pop,
  input logic                     cfg_ready,
  input logic                     inside_res,
  input logic signed [CoordW-1:0] pixel_x,
  input logic signed [CoordW-1:0] pixel_y,
  input logic [ColorW-1:0]        pixel_color
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result side not empty after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("config port not ready");

  a_inside: assert property (@(posedge clk) disable iff (rst)
    (!empty && inside_res) |-> (pixel_x >= 0 && pixel_x <= ImageWidth &&
                                pixel_y >= 0 && pixel_y <= ImageHeight))
    else $error("inside flag on a clipped pixel");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(pixel_color) && $stable(pixel_x)))
    else $error("waiting result changed");

endmodule

bind gradient_line_rasterizer_top glr_checker u_glr_checker (
  .clk         (clk),
  .rst         (rst),
  .empty       (empty),
  .pop         (pop),
  .cfg_ready   (cfg_ready),
  .inside_res  (inside_res),
  .pixel_x     (pixel_x),
  .pixel_y     (pixel_y),
  .pixel_color (pixel_color)
);

// ===== tb/sv/tb_gradient_line_rasterizer_top.sv =====
// ----------------------------------------------------------------------------
// tb_gradient_line_rasterizer_top
// self-checking bench for the gradient line rasterizer
// ----------------------------------------------------------------------------
// short lines and step bursts are pushed through the input queue under
// random sender and receiver idling. a scoreboard walks each line with its
// own stepper and color blend and checks every popped pixel in order.
// ----------------------------------------------------------------------------
module tb_gradient_line_rasterizer_top;
  import glr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 1000000;
  localparam int SettleCycles = 200;

  typedef struct {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic [ColorW-1:0]        color;
    logic                     in_image;
    logic                     last;
  } pixel_t;

  class pixel_scoreboard;
    pixel_t pixel_q[$];
    int errors;
    logic [ColorW-1:0] first_color, second_color;
    int cur_x, cur_y, org_x, org_y, tgt_x, tgt_y, span_x, span_y, err_term;
    bit neg_x, neg_y, active;
    color_mode_t mode;

    function new();
      errors = 0; first_color = '0; second_color = '0;
      cur_x = 0; cur_y = 0; org_x = 0; org_y = 0; tgt_x = 0; tgt_y = 0;
      span_x = 0; span_y = 0; err_term = 0;
      neg_x = 0; neg_y = 0; active = 0; mode = MODE_SECOND;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function logic [ColorW-1:0] blend_color(int px, int py);
      longint fx, fy, cx, cy;
      longint unsigned f2, c2, p, a, b, c;
      logic [ColorW-1:0] res;
      fx = tgt_x - org_x; fy = tgt_y - org_y;
      cx = px - org_x; cy = py - org_y;
      f2 = fx * fx + fy * fy;
      c2 = cx * cx + cy * cy;
      p = 65536;
      res = '0;
      if (f2 != 0) begin
        p = int_sqrt((c2 << 32) / f2);
        if (p > 65536) p = 65536;
      end
      for (int sh = 0; sh <= 16; sh += 8) begin
        a = (first_color >> sh) & 8'hff;
        b = (second_color >> sh) & 8'hff;
        c = (a * (65536 - p) + b * p + 32768) >> 16;
        if (c > 255) c = 255;
        res |= c[7:0] << sh;
      end
      return res;
    endfunction

    function void write_reg(reg_index_t idx, logic [ColorW-1:0] val);
      if (idx == REG_FIRST_COLOR) first_color = val;
      else second_color = val;
    endfunction

    function void note_request(opcode_t op, int xs, int ys, int xe, int ye,
                               int zs, int ze);
      pixel_t px;
      int e2;
      if (op == OP_LOAD) begin
        org_x = xs; org_y = ys; tgt_x = xe; tgt_y = ye;
        cur_x = xs; cur_y = ys;
        span_x = (xe > xs) ? xe - xs : xs - xe;
        span_y = (ye > ys) ? ye - ys : ys - ye;
        neg_x = !(xs < xe);
        neg_y = !(ys < ye);
        err_term = span_x - span_y;
        if (zs == ze) mode = (zs == 0) ? MODE_SECOND : MODE_FIRST;
        else mode = MODE_BLEND;
        active = !(xs == xe && ys == ye);
        return;
      end
      if (!active) return;
      px.x = cur_x; px.y = cur_y;
      if (mode == MODE_SECOND) px.color = second_color;
      else if (mode == MODE_FIRST) px.color = first_color;
      else px.color = blend_color(cur_x, cur_y);
      px.in_image = cur_x >= 0 && cur_x <= int'(ImageWidth) &&
                    cur_y >= 0 && cur_y <= int'(ImageHeight);
      e2 = 2 * err_term;
      if (e2 > -span_y) begin
        err_term -= span_y;
        cur_x += neg_x ? -1 : 1;
      end
      if (e2 < span_x) begin
        err_term += span_x;
        cur_y += neg_y ? -1 : 1;
      end
      px.last = (cur_x == tgt_x && cur_y == tgt_y);
      if (px.last) active = 0;
      pixel_q.push_back(px);
    endfunction

    task check_pixel(pixel_t got);
      pixel_t exp_px;
      if (pixel_q.size() == 0) begin
        report($sformatf("unexpected pixel x=%0d y=%0d", got.x, got.y));
        return;
      end
      exp_px = pixel_q.pop_front();
      if (got.x !== exp_px.x)
        report($sformatf("pixel_x got %0d exp %0d", got.x, exp_px.x));
      if (got.y !== exp_px.y)
        report($sformatf("pixel_y got %0d exp %0d", got.y, exp_px.y));
      if (got.color !== exp_px.color)
        report($sformatf("pixel_color got %h exp %h at %0d,%0d",
                         got.color, exp_px.color, exp_px.x, exp_px.y));
      if (got.in_image !== exp_px.in_image)
        report($sformatf("inside_res got %b exp %b", got.in_image, exp_px.in_image));
      if (got.last !== exp_px.last)
        report($sformatf("last got %b exp %b", got.last, exp_px.last));
    endtask
  endclass

  logic clk, rst;
  logic push, full, opcode;
  logic signed [CoordW-1:0] x_start, y_start, x_end, y_end;
  logic signed [15:0] z_start, z_end;
  logic empty, pop;
  logic signed [CoordW-1:0] pixel_x, pixel_y;
  logic [ColorW-1:0] pixel_color;
  logic inside_res, last;
  logic cfg_valid, cfg_ready, cfg_index;
  logic [ColorW-1:0] cfg_data;

  pixel_scoreboard sb = new();
  int send_idle, recv_idle, hold_cnt, cycles, n_items;
  logic hold_go;

  gradient_line_rasterizer_top u_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .opcode(opcode),
    .x_start(x_start), .y_start(y_start), .x_end(x_end), .y_end(y_end),
    .z_start(z_start), .z_end(z_end), .empty(empty), .pop(pop),
    .pixel_x(pixel_x), .pixel_y(pixel_y), .pixel_color(pixel_color),
    .inside_res(inside_res), .last(last), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial clk = 0;
  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
    else if (hold_go) hold_cnt <= 400;
  end

  always @(posedge clk) begin
    pixel_t got;
    if (!rst && pop && !empty) begin
      got.x = pixel_x; got.y = pixel_y; got.color = pixel_color;
      got.in_image = inside_res; got.last = last;
      sb.check_pixel(got);
    end
    pop <= !rst && hold_cnt == 0 && $urandom_range(99) >= recv_idle;
  end

  task send_request(opcode_t op, int xs, int ys, int xe, int ye, int zs, int ze);
    opcode <= op;
    x_start <= xs; y_start <= ys; x_end <= xe; y_end <= ye;
    z_start <= zs; z_end <= ze;
    push <= 1;
    do @(posedge clk); while (full);
    sb.note_request(op, xs, ys, xe, ye, zs, ze);
    n_items++;
    if ($urandom_range(99) < send_idle) begin
      push <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task write_cfg(reg_index_t idx, logic [ColorW-1:0] val);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task drain();
    push <= 0;
    @(posedge clk);
    while (sb.pixel_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  function int pick_coord(int mode_sel);
    case (mode_sel)
      0: return $urandom_range(0, 1100) - 40;
      1: return $urandom_range(1010, 1040);
      2: return $urandom_range(0, 20) - 10;
      default: return int'($urandom_range(8191)) - 4096;
    endcase
  endfunction

  function int pick_height();
    case ($urandom_range(3))
      0: return 0;
      1: return 1234;
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  function int clamp_end(int s, int d);
    if (s + d > 4095 || s + d < -4096) return s - d;
    return s + d;
  endfunction

  task random_line();
    int xs, ys, xe, ye, zs, ze, n, sel;
    sel = $urandom_range(9);
    xs = pick_coord(sel < 6 ? 0 : (sel < 8 ? 1 : 2));
    ys = (sel == 7) ? $urandom_range(755, 780) : pick_coord(sel < 6 ? 0 : 2);
    xe = clamp_end(xs, int'($urandom_range(24)) - 12);
    ye = clamp_end(ys, int'($urandom_range(24)) - 12);
    zs = pick_height();
    ze = ($urandom_range(2) == 0) ? zs : pick_height();
    send_request(OP_LOAD, xs, ys, xe, ye, zs, ze);
    n = ((xe > xs) ? xe - xs : xs - xe);
    if (((ye > ys) ? ye - ys : ys - ye) > n) n = (ye > ys) ? ye - ys : ys - ye;
    n += $urandom_range(2);
    repeat (n)
      send_request(OP_STEP, pick_coord(3), pick_coord(3), pick_coord(3),
                   pick_coord(3), pick_height(), pick_height());
  endtask

  task noise_burst();
    if ($urandom_range(1) == 0)
      send_request(OP_LOAD, pick_coord(3), pick_coord(3), pick_coord(3),
                   pick_coord(3), pick_height(), pick_height());
    repeat ($urandom_range(1, 4))
      send_request(OP_STEP, pick_coord(3), pick_coord(3), pick_coord(3),
                   pick_coord(3), pick_height(), pick_height());
  endtask

  task random_phase(int count);
    int stop;
    stop = n_items + count;
    while (n_items < stop) begin
      if ($urandom_range(9) < 8) random_line();
      else noise_burst();
    end
  endtask

  initial begin
    rst = 1; push = 0; opcode = OP_LOAD; pop = 0;
    x_start = 0; y_start = 0; x_end = 0; y_end = 0; z_start = 0; z_end = 0;
    cfg_valid = 0; cfg_index = REG_FIRST_COLOR; cfg_data = '0;
    hold_go = 0; hold_cnt = 0; cycles = 0; n_items = 0;
    send_idle = 0; recv_idle = 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: step with no line, zero-length line, flat and blended colors
    send_request(OP_STEP, 5, 5, 9, 9, 1, 2);
    send_request(OP_LOAD, 7, 7, 7, 7, 3, 9);
    send_request(OP_STEP, 0, 0, 0, 0, 0, 0);
    send_request(OP_LOAD, 0, 0, 3, 1, 0, 0);
    repeat (3) send_request(OP_STEP, 0, 0, 0, 0, 0, 0);
    drain();
    write_cfg(REG_FIRST_COLOR, 24'hffffff);
    write_cfg(REG_SECOND_COLOR, 24'h000000);
    send_request(OP_LOAD, 1022, 768, 1026, 768, -32768, -32768);
    repeat (4) send_request(OP_STEP, 0, 0, 0, 0, 0, 0);
    send_request(OP_LOAD, 2, 770, -1, 765, 32767, -32768);
    repeat (5) send_request(OP_STEP, 0, 0, 0, 0, 0, 0);
    send_request(OP_LOAD, -4096, 4095, 4095, -4096, 0, 1);
    repeat (3) send_request(OP_STEP, -1, -1, -1, -1, -1, -1);
    send_request(OP_LOAD, 0, 0, 0, 1, 5, 6);
    send_request(OP_STEP, 0, 0, 0, 0, 0, 0);
    drain();

    write_cfg(REG_FIRST_COLOR, 24'h123456);
    write_cfg(REG_SECOND_COLOR, 24'hfedcba);
    send_idle = 24; recv_idle = 79;
    random_phase(180);
    hold_go <= 1;
    @(posedge clk);
    hold_go <= 0;
    random_phase(180);
    drain();

    write_cfg(REG_FIRST_COLOR, 24'h000000);
    write_cfg(REG_SECOND_COLOR, 24'hffffff);
    send_idle = 79; recv_idle = 24;
    random_phase(360);
    drain();

    write_cfg(REG_FIRST_COLOR, $urandom_range(24'hffffff));
    write_cfg(REG_SECOND_COLOR, $urandom_range(24'hffffff));
    send_idle = 0; recv_idle = 0;
    random_phase(360);
    drain();

    if (sb.pixel_q.size() != 0) sb.report("pixels still expected at end");
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
